### design/ata_seq_pkg.sv
// ata_seq_pkg: shared types, codes and constants of the ATA PIO sector sequencer
// used by every module under design/; depends on nothing else
`timescale 1ns / 1ps

package ata_seq_pkg;

    // sizing
    localparam int SECTOR_WORDS  = 256;
    localparam int DUMMY_READS   = 4;
    localparam int WORD_W        = $clog2(SECTOR_WORDS + 1);
    localparam int DUMMY_W       = $clog2(DUMMY_READS + 1);
    localparam int BATCH_DEPTH   = 8;
    localparam int BATCH_CNT_W   = $clog2(BATCH_DEPTH + 1);
    localparam int NUM_DRIVES    = 4;
    localparam int SIZE_W        = 29;
    localparam int POLL_W        = 17;
    localparam int LBA_W         = 28;
    localparam int COUNT_W       = 16;
    localparam int CFG_INDEX_W   = 3;

    localparam logic [WORD_W-1:0]  SECTOR_WORDS_V = WORD_W'(SECTOR_WORDS);
    localparam logic [DUMMY_W-1:0] DUMMY_READS_V  = DUMMY_W'(DUMMY_READS);

    // input modes
    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_RESP  = 2'd1;
    localparam logic [1:0] MODE_HWORD = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_BUS_WRITE = 2'd0;
    localparam logic [1:0] KIND_BUS_READ  = 2'd1;
    localparam logic [1:0] KIND_HOST_WORD = 2'd2;
    localparam logic [1:0] KIND_DONE      = 2'd3;

    // done status
    localparam logic [2:0] STATUS_OK       = 3'd0;
    localparam logic [2:0] STATUS_REJECTED = 3'd1;
    localparam logic [2:0] STATUS_BEYOND   = 3'd2;
    localparam logic [2:0] STATUS_FAULT    = 3'd3;
    localparam logic [2:0] STATUS_TIMEOUT  = 3'd4;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] CFG_SECTORS_DEV0 = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECTORS_DEV1 = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECTORS_DEV2 = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SECTORS_DEV3 = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_POLL_LIMIT   = 3'd4;

    localparam logic [POLL_W-1:0] POLL_LIMIT_RESET = 17'd100000;

    // bus addresses
    localparam logic [9:0] IO_PRI   = 10'h1F0;
    localparam logic [9:0] CTRL_PRI = 10'h3F6;
    localparam logic [9:0] IO_SEC   = 10'h170;
    localparam logic [9:0] CTRL_SEC = 10'h376;

    // task-file values and status bits
    localparam logic [7:0] SEL_BASE  = 8'hE0;
    localparam logic [7:0] CMD_READ  = 8'h20;
    localparam logic [7:0] CMD_WRITE = 8'h30;
    localparam int ST_ERR_BIT = 0;
    localparam int ST_DRQ_BIT = 3;
    localparam int ST_DF_BIT  = 5;
    localparam int ST_BSY_BIT = 7;

    typedef enum logic [7:0] {
        PH_IDLE  = 8'b0000_0001,
        PH_SEL   = 8'b0000_0010,
        PH_BSY   = 8'b0000_0100,
        PH_DRQ   = 8'b0000_1000,
        PH_RDATA = 8'b0001_0000,
        PH_WDATA = 8'b0010_0000,
        PH_POST  = 8'b0100_0000,
        PH_FIN   = 8'b1000_0000
    } phase_t;

    typedef struct packed {
        logic [1:0]         mode;
        logic               is_write;
        logic [1:0]         device;
        logic [LBA_W-1:0]   start_lba;
        logic [COUNT_W-1:0] sector_count;
        logic [15:0]        data_in;
    } req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [9:0]  port;
        logic        wide;
        logic [15:0] data_out;
        logic [2:0]  status;
        logic        last;
    } rsp_t;

    typedef rsp_t [BATCH_DEPTH-1:0] batch_t;

    typedef struct packed {
        logic [NUM_DRIVES-1:0][SIZE_W-1:0] sectors;
        logic [POLL_W-1:0]                 poll_limit;
    } cfg_t;

    function automatic rsp_t mk_rsp(logic [1:0] kind, logic [9:0] port, logic wide,
                                    logic [15:0] data, logic [2:0] status);
        rsp_t r;
        r.kind     = kind;
        r.port     = port;
        r.wide     = wide;
        r.data_out = data;
        r.status   = status;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic logic [9:0] io_base(logic [1:0] drive);
        return drive[1] ? IO_SEC : IO_PRI;
    endfunction

    function automatic logic [9:0] ctrl_base(logic [1:0] drive);
        return drive[1] ? CTRL_SEC : CTRL_PRI;
    endfunction

    // drive/head select byte with LBA mode and the top address nibble
    function automatic logic [15:0] sel_byte(logic [1:0] drive, logic [LBA_W-1:0] lba);
        return {8'h00, SEL_BASE[7:5], drive[0], lba[LBA_W-1:LBA_W-4]};
    endfunction

endpackage

### design/ata_seq_engine.sv
// ata_seq_engine: sequencer state and the single-pass logic that turns one request
// into a batch of bus/host results; depends on ata_seq_pkg
`timescale 1ns / 1ps

module ata_seq_engine (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               take,
    input  ata_seq_pkg::req_t                  item,
    input  ata_seq_pkg::cfg_t                  cfg,
    output ata_seq_pkg::batch_t                batch,
    output logic [ata_seq_pkg::BATCH_CNT_W-1:0] batch_cnt
);

    ata_seq_pkg::phase_t                    phase_reg, phase_next;
    logic [ata_seq_pkg::LBA_W-1:0]          lba_reg, lba_next;
    logic [ata_seq_pkg::COUNT_W-1:0]        remaining_reg, remaining_next;
    logic [ata_seq_pkg::WORD_W-1:0]         word_reg, word_next;
    logic [ata_seq_pkg::DUMMY_W-1:0]        dummy_reg, dummy_next;
    logic [ata_seq_pkg::POLL_W-1:0]         poll_reg, poll_next;
    logic [1:0]                             drive_reg, drive_next;
    logic                                   write_op_reg, write_op_next;

    logic [9:0]                             io;
    logic [9:0]                             ctrl;
    logic [7:0]                             st;
    logic                                   st_fault;
    logic [ata_seq_pkg::POLL_W-1:0]         poll_inc;
    logic                                   poll_out;
    logic [ata_seq_pkg::WORD_W-1:0]         word_inc;
    logic [ata_seq_pkg::DUMMY_W-1:0]        dummy_inc;
    logic [ata_seq_pkg::COUNT_W-1:0]        rem_dec;
    logic [ata_seq_pkg::LBA_W-1:0]          lba_inc;
    logic [ata_seq_pkg::SIZE_W-1:0]         drive_size;
    logic [ata_seq_pkg::SIZE_W-1:0]         req_end;
    logic                                   poll_match;

    assign io        = ata_seq_pkg::io_base(drive_reg);
    assign ctrl      = ata_seq_pkg::ctrl_base(drive_reg);
    assign st        = item.data_in[7:0];
    assign st_fault  = st[ata_seq_pkg::ST_ERR_BIT] | st[ata_seq_pkg::ST_DF_BIT];
    assign poll_inc  = poll_reg + 1'b1;
    assign poll_out  = poll_inc >= cfg.poll_limit;
    assign word_inc  = word_reg + 1'b1;
    assign dummy_inc = dummy_reg + 1'b1;
    assign rem_dec   = remaining_reg - 1'b1;
    assign lba_inc   = lba_reg + 1'b1;
    assign drive_size = cfg.sectors[item.device];
    // one bit wider than the lba so the sum cannot wrap
    assign req_end   = {1'b0, item.start_lba}
                     + {{(ata_seq_pkg::SIZE_W - ata_seq_pkg::COUNT_W){1'b0}}, item.sector_count};

    always_comb
    begin
        phase_next     = phase_reg;
        lba_next       = lba_reg;
        remaining_next = remaining_reg;
        word_next      = word_reg;
        dummy_next     = dummy_reg;
        poll_next      = poll_reg;
        drive_next     = drive_reg;
        write_op_next  = write_op_reg;
        batch          = '0;
        batch_cnt      = '0;
        poll_match     = 1'b0;

        case (item.mode)
            ata_seq_pkg::MODE_START:
            begin
                if (phase_reg == ata_seq_pkg::PH_IDLE)
                begin
                    if (drive_size == '0 || item.sector_count == '0)
                    begin
                        batch[0]  = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_DONE, 10'd0, 1'b0,
                                                        16'd0, ata_seq_pkg::STATUS_REJECTED);
                        batch_cnt = 4'd1;
                    end
                    else if (req_end > drive_size)
                    begin
                        batch[0]  = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_DONE, 10'd0, 1'b0,
                                                        16'd0, ata_seq_pkg::STATUS_BEYOND);
                        batch_cnt = 4'd1;
                    end
                    else
                    begin
                        drive_next     = item.device;
                        write_op_next  = item.is_write;
                        lba_next       = item.start_lba;
                        remaining_next = item.sector_count;
                        word_next      = '0;
                        dummy_next     = '0;
                        phase_next     = ata_seq_pkg::PH_SEL;
                        batch[0] = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_WRITE,
                                       ata_seq_pkg::io_base(item.device) + 10'd6, 1'b0,
                                       ata_seq_pkg::sel_byte(item.device, item.start_lba),
                                       ata_seq_pkg::STATUS_OK);
                        batch[1] = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_READ,
                                       ata_seq_pkg::ctrl_base(item.device), 1'b0, 16'd0,
                                       ata_seq_pkg::STATUS_OK);
                        batch_cnt = 4'd2;
                    end
                end
            end

            ata_seq_pkg::MODE_RESP:
            begin
                case (phase_reg)
                    ata_seq_pkg::PH_SEL:
                    begin
                        dummy_next = dummy_inc;
                        if (dummy_inc < ata_seq_pkg::DUMMY_READS_V)
                        begin
                            batch[0]  = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_READ, ctrl,
                                            1'b0, 16'd0, ata_seq_pkg::STATUS_OK);
                            batch_cnt = 4'd1;
                        end
                        else
                        begin
                            // whole task file in one go, then the first busy poll
                            batch[0] = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_WRITE,
                                           io + 10'd1, 1'b0, 16'd0, ata_seq_pkg::STATUS_OK);
                            batch[1] = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_WRITE,
                                           io + 10'd2, 1'b0, 16'd1, ata_seq_pkg::STATUS_OK);
                            batch[2] = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_WRITE,
                                           io + 10'd3, 1'b0, {8'h00, lba_reg[7:0]},
                                           ata_seq_pkg::STATUS_OK);
                            batch[3] = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_WRITE,
                                           io + 10'd4, 1'b0, {8'h00, lba_reg[15:8]},
                                           ata_seq_pkg::STATUS_OK);
                            batch[4] = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_WRITE,
                                           io + 10'd5, 1'b0, {8'h00, lba_reg[23:16]},
                                           ata_seq_pkg::STATUS_OK);
                            batch[5] = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_WRITE,
                                           io + 10'd7, 1'b0,
                                           {8'h00, write_op_reg ? ata_seq_pkg::CMD_WRITE
                                                                : ata_seq_pkg::CMD_READ},
                                           ata_seq_pkg::STATUS_OK);
                            batch[6] = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_READ,
                                           io + 10'd7, 1'b0, 16'd0, ata_seq_pkg::STATUS_OK);
                            batch_cnt  = 4'd7;
                            poll_next  = '0;
                            phase_next = ata_seq_pkg::PH_BSY;
                        end
                    end

                    ata_seq_pkg::PH_BSY,
                    ata_seq_pkg::PH_DRQ,
                    ata_seq_pkg::PH_FIN:
                    begin
                        poll_match = (phase_reg == ata_seq_pkg::PH_DRQ)
                                   ? st[ata_seq_pkg::ST_DRQ_BIT]
                                   : !st[ata_seq_pkg::ST_BSY_BIT];
                        if (st_fault)
                        begin
                            phase_next = ata_seq_pkg::PH_IDLE;
                            batch[0]   = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_DONE, 10'd0,
                                             1'b0, 16'd0, ata_seq_pkg::STATUS_FAULT);
                            batch_cnt  = 4'd1;
                        end
                        else if (!poll_match)
                        begin
                            poll_next = poll_inc;
                            if (poll_out)
                            begin
                                phase_next = ata_seq_pkg::PH_IDLE;
                                batch[0]   = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_DONE,
                                                 10'd0, 1'b0, 16'd0,
                                                 ata_seq_pkg::STATUS_TIMEOUT);
                            end
                            else
                            begin
                                batch[0] = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_READ,
                                               io + 10'd7, 1'b0, 16'd0,
                                               ata_seq_pkg::STATUS_OK);
                            end
                            batch_cnt = 4'd1;
                        end
                        else
                        begin
                            poll_next = '0;
                            if (phase_reg == ata_seq_pkg::PH_BSY)
                            begin
                                phase_next = ata_seq_pkg::PH_DRQ;
                                batch[0]   = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_READ,
                                                 io + 10'd7, 1'b0, 16'd0,
                                                 ata_seq_pkg::STATUS_OK);
                                batch_cnt  = 4'd1;
                            end
                            else if (phase_reg == ata_seq_pkg::PH_DRQ)
                            begin
                                word_next = '0;
                                if (write_op_reg)
                                begin
                                    phase_next = ata_seq_pkg::PH_WDATA;
                                end
                                else
                                begin
                                    phase_next = ata_seq_pkg::PH_RDATA;
                                    batch[0]   = ata_seq_pkg::mk_rsp(
                                                     ata_seq_pkg::KIND_BUS_READ, io, 1'b1,
                                                     16'd0, ata_seq_pkg::STATUS_OK);
                                    batch_cnt  = 4'd1;
                                end
                            end
                            else
                            begin
                                // write sector finished: next sector or done
                                remaining_next = rem_dec;
                                lba_next       = lba_inc;
                                if (rem_dec == '0)
                                begin
                                    phase_next = ata_seq_pkg::PH_IDLE;
                                    batch[0]   = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_DONE,
                                                     10'd0, 1'b0, 16'd0,
                                                     ata_seq_pkg::STATUS_OK);
                                    batch_cnt  = 4'd1;
                                end
                                else
                                begin
                                    phase_next = ata_seq_pkg::PH_SEL;
                                    dummy_next = '0;
                                    batch[0]   = ata_seq_pkg::mk_rsp(
                                                     ata_seq_pkg::KIND_BUS_WRITE, io + 10'd6,
                                                     1'b0,
                                                     ata_seq_pkg::sel_byte(drive_reg, lba_inc),
                                                     ata_seq_pkg::STATUS_OK);
                                    batch[1]   = ata_seq_pkg::mk_rsp(
                                                     ata_seq_pkg::KIND_BUS_READ, ctrl, 1'b0,
                                                     16'd0, ata_seq_pkg::STATUS_OK);
                                    batch_cnt  = 4'd2;
                                end
                            end
                        end
                    end

                    ata_seq_pkg::PH_RDATA:
                    begin
                        word_next = word_inc;
                        batch[0]  = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_HOST_WORD, 10'd0,
                                        1'b0, item.data_in, ata_seq_pkg::STATUS_OK);
                        if (word_inc < ata_seq_pkg::SECTOR_WORDS_V)
                        begin
                            batch[1] = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_READ, io,
                                           1'b1, 16'd0, ata_seq_pkg::STATUS_OK);
                        end
                        else
                        begin
                            dummy_next = '0;
                            phase_next = ata_seq_pkg::PH_POST;
                            batch[1]   = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_READ, ctrl,
                                             1'b0, 16'd0, ata_seq_pkg::STATUS_OK);
                        end
                        batch_cnt = 4'd2;
                    end

                    ata_seq_pkg::PH_POST:
                    begin
                        dummy_next = dummy_inc;
                        if (dummy_inc < ata_seq_pkg::DUMMY_READS_V)
                        begin
                            batch[0]  = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_READ, ctrl,
                                            1'b0, 16'd0, ata_seq_pkg::STATUS_OK);
                            batch_cnt = 4'd1;
                        end
                        else if (write_op_reg)
                        begin
                            poll_next  = '0;
                            phase_next = ata_seq_pkg::PH_FIN;
                            batch[0]   = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_READ,
                                             io + 10'd7, 1'b0, 16'd0,
                                             ata_seq_pkg::STATUS_OK);
                            batch_cnt  = 4'd1;
                        end
                        else
                        begin
                            remaining_next = rem_dec;
                            lba_next       = lba_inc;
                            if (rem_dec == '0)
                            begin
                                phase_next = ata_seq_pkg::PH_IDLE;
                                batch[0]   = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_DONE,
                                                 10'd0, 1'b0, 16'd0,
                                                 ata_seq_pkg::STATUS_OK);
                                batch_cnt  = 4'd1;
                            end
                            else
                            begin
                                phase_next = ata_seq_pkg::PH_SEL;
                                dummy_next = '0;
                                batch[0]   = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_WRITE,
                                                 io + 10'd6, 1'b0,
                                                 ata_seq_pkg::sel_byte(drive_reg, lba_inc),
                                                 ata_seq_pkg::STATUS_OK);
                                batch[1]   = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_READ,
                                                 ctrl, 1'b0, 16'd0,
                                                 ata_seq_pkg::STATUS_OK);
                                batch_cnt  = 4'd2;
                            end
                        end
                    end

                    default:
                    begin
                    end
                endcase
            end

            ata_seq_pkg::MODE_HWORD:
            begin
                if (phase_reg == ata_seq_pkg::PH_WDATA)
                begin
                    word_next = word_inc;
                    batch[0]  = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_WRITE, io, 1'b1,
                                    item.data_in, ata_seq_pkg::STATUS_OK);
                    batch_cnt = 4'd1;
                    if (word_inc >= ata_seq_pkg::SECTOR_WORDS_V)
                    begin
                        dummy_next = '0;
                        phase_next = ata_seq_pkg::PH_POST;
                        batch[1]   = ata_seq_pkg::mk_rsp(ata_seq_pkg::KIND_BUS_READ, ctrl,
                                         1'b0, 16'd0, ata_seq_pkg::STATUS_OK);
                        batch_cnt  = 4'd2;
                    end
                end
            end

            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= ata_seq_pkg::PH_IDLE;
            lba_reg       <= '0;
            remaining_reg <= '0;
            word_reg      <= '0;
            dummy_reg     <= '0;
            poll_reg      <= '0;
            drive_reg     <= '0;
            write_op_reg  <= 1'b0;
        end
        else if (take)
        begin
            phase_reg     <= phase_next;
            lba_reg       <= lba_next;
            remaining_reg <= remaining_next;
            word_reg      <= word_next;
            dummy_reg     <= dummy_next;
            poll_reg      <= poll_next;
            drive_reg     <= drive_next;
            write_op_reg  <= write_op_next;
        end
    end

endmodule

### design/ata_seq_outq.sv
// ata_seq_outq: result buffer that holds one request's batch and hands it out one
// result per handshake, marking the final one; depends on ata_seq_pkg
`timescale 1ns / 1ps

module ata_seq_outq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                load,
    input  ata_seq_pkg::batch_t                 batch,
    input  logic [ata_seq_pkg::BATCH_CNT_W-1:0] batch_cnt,
    output logic                                free,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output ata_seq_pkg::rsp_t                   rsp
);

    ata_seq_pkg::batch_t                 buf_reg, buf_next;
    logic [ata_seq_pkg::BATCH_CNT_W-1:0] cnt_reg, cnt_next;
    logic                                pop;

    assign rsp_valid = cnt_reg != '0;
    assign rsp       = buf_reg[0];
    assign pop       = rsp_valid && !rsp_stall;
    // a new batch may land while the last held result leaves
    assign free      = (cnt_reg == '0) || (cnt_reg == 4'd1 && pop);

    always_comb
    begin
        buf_next = buf_reg;
        cnt_next = cnt_reg;
        if (load)
        begin
            for (int i = 0; i < ata_seq_pkg::BATCH_DEPTH; i++)
            begin
                buf_next[i]      = batch[i];
                buf_next[i].last = (ata_seq_pkg::BATCH_CNT_W'(i + 1) == batch_cnt);
            end
            cnt_next = batch_cnt;
        end
        else if (pop)
        begin
            for (int i = 0; i < ata_seq_pkg::BATCH_DEPTH - 1; i++)
            begin
                buf_next[i] = buf_reg[i + 1];
            end
            buf_next[ata_seq_pkg::BATCH_DEPTH-1] = '0;
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
    end

endmodule

### design/ata_pio_sector_sequencer.sv
// ata_pio_sector_sequencer: top level with request register, configuration registers,
// sequencer engine and result buffer; depends on ata_seq_pkg, ata_seq_engine, ata_seq_outq
`timescale 1ns / 1ps

// Host-side ATA PIO sequencer.
// req channel (req_valid/req_stall/req): start requests, bus read responses and host
// write words. rsp channel (rsp_valid/rsp_stall/rsp): bus writes, bus read requests,
// host read words and one done per request; last marks the final result of a request.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): drive sizes and poll limit,
// always ready, written by the user only while the block is idle (the block does not
// enforce this); other indexes are dropped. A request is held in the request register;
// once the result buffer is free it is processed and its first result is shown on rsp.
// Throughput: one request per cycle while each causes at most one result and rsp is not
// stalled; the result buffer empties one result per cycle while rsp is not stalled, so
// a request with n results holds the request register until all of them have left
// (task-file setup gives seven, read data two); requests with no result load nothing.
// Stall on rsp holds the current result; the request register then fills and req_stall
// rises until the buffer frees up.
// Reset clears the sequencer to idle, drive sizes to zero (no drive) and the poll
// limit to 100000; no clearing pass is needed.

module ata_pio_sector_sequencer (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                req_valid,
    output logic                                req_stall,
    input  ata_seq_pkg::req_t                   req,
    output logic                                rsp_valid,
    input  logic                                rsp_stall,
    output ata_seq_pkg::rsp_t                   rsp,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [ata_seq_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [ata_seq_pkg::SIZE_W-1:0]      cfg_data
);

    logic                                full_reg, full_next;
    ata_seq_pkg::req_t                   item_reg;
    ata_seq_pkg::cfg_t                   cfg_reg;
    logic                                take;
    logic                                free;
    logic                                accept;
    ata_seq_pkg::batch_t                 batch;
    logic [ata_seq_pkg::BATCH_CNT_W-1:0] batch_cnt;

    assign cfg_ready = 1'b1;
    assign take      = full_reg && free;
    assign req_stall = full_reg && !take;
    assign accept    = req_valid && !req_stall;
    assign full_next = accept ? 1'b1 : (take ? 1'b0 : full_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_reg <= 1'b0;
        end
        else
        begin
            full_reg <= full_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            item_reg <= req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sectors    <= '0;
            cfg_reg.poll_limit <= ata_seq_pkg::POLL_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                ata_seq_pkg::CFG_SECTORS_DEV0: cfg_reg.sectors[0] <= cfg_data;
                ata_seq_pkg::CFG_SECTORS_DEV1: cfg_reg.sectors[1] <= cfg_data;
                ata_seq_pkg::CFG_SECTORS_DEV2: cfg_reg.sectors[2] <= cfg_data;
                ata_seq_pkg::CFG_SECTORS_DEV3: cfg_reg.sectors[3] <= cfg_data;
                ata_seq_pkg::CFG_POLL_LIMIT:
                    cfg_reg.poll_limit <= cfg_data[ata_seq_pkg::POLL_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    ata_seq_engine u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .item      (item_reg),
        .cfg       (cfg_reg),
        .batch     (batch),
        .batch_cnt (batch_cnt)
    );

    ata_seq_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (take && batch_cnt != '0),
        .batch     (batch),
        .batch_cnt (batch_cnt),
        .free      (free),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    // stall only comes from a held request
    assert property (@(posedge clk) disable iff (!rst_n) req_stall |-> full_reg)
        else $error("request stalled with empty request register");

    // a processed request with results shows one on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (take && batch_cnt != '0) |=> rsp_valid)
        else $error("batch loaded but no result offered");

    // done always closes the results of its request
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.kind == ata_seq_pkg::KIND_DONE) |-> rsp.last)
        else $error("done result not marked last");

    // only done carries a status
    assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.kind != ata_seq_pkg::KIND_DONE) |->
            rsp.status == ata_seq_pkg::STATUS_OK)
        else $error("status set on a non-done result");

endmodule

### tb/tb_top.sv
// tb_top: self-checking testbench for ata_pio_sector_sequencer
// depends on ata_seq_pkg and the sequencer RTL; predicts every result and checks it in order
`timescale 1ns / 1ps

module tb_top;
    import ata_seq_pkg::*;

    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_UNUSED_INDEX = 3'd7;
    localparam logic [7:0] STAT_ERR = 8'h01 << ST_ERR_BIT;
    localparam logic [7:0] STAT_DRQ = 8'h01 << ST_DRQ_BIT;
    localparam logic [7:0] STAT_DF  = 8'h01 << ST_DF_BIT;
    localparam logic [7:0] STAT_BSY = 8'h01 << ST_BSY_BIT;

    typedef enum logic [1:0] {BY_MODEL, NO_RESULT, DONE_WITH, SETUP_DRIVES} row_check_e;

    typedef struct {
        row_check_e check;
        logic [2:0] status;
        req_t       item;
    } script_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_stall;
    req_t req;
    logic rsp_valid;
    logic rsp_stall;
    rsp_t rsp;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [SIZE_W-1:0] cfg_data;

    // predicted sequencer state and register copies
    logic [SIZE_W-1:0]  drive_size [NUM_DRIVES];
    logic [POLL_W-1:0]  poll_max;
    phase_t             pr_phase;
    logic [LBA_W-1:0]   pr_lba;
    logic [COUNT_W-1:0] pr_left;
    int                 pr_word;
    int                 pr_dummy;
    logic [POLL_W-1:0]  pr_polls;
    logic [1:0]         pr_drive;
    logic               pr_write;

    rsp_t results_due [$];
    script_row_t script [$];
    int mismatch_count = 0;
    int fault_odds = 0;
    int steady_left = 0;

    ata_pio_sector_sequencer i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    function automatic logic [9:0] io_addr();
        return pr_drive[1] ? IO_SEC : IO_PRI;
    endfunction

    function automatic logic [9:0] ctl_addr();
        return pr_drive[1] ? CTRL_SEC : CTRL_PRI;
    endfunction

    function automatic rsp_t result_of(logic [1:0] kind, logic [9:0] port, logic wide,
                                       logic [15:0] data, logic [2:0] status);
        rsp_t r;
        r.kind     = kind;
        r.port     = port;
        r.wide     = wide;
        r.data_out = data;
        r.status   = status;
        r.last     = 1'b0;
        return r;
    endfunction

    function automatic void close_request(logic [2:0] status, ref rsp_t res [$]);
        pr_phase = PH_IDLE;
        res.push_back(result_of(KIND_DONE, 10'h000, 1'b0, 16'h0000, status));
    endfunction

    function automatic void open_sector(ref rsp_t res [$]);
        logic [7:0] sel;
        sel = SEL_BASE | {3'b000, pr_drive[0], pr_lba[LBA_W-1:LBA_W-4]};
        res.push_back(result_of(KIND_BUS_WRITE, io_addr() + 10'd6, 1'b0, {8'h00, sel},
                                STATUS_OK));
        pr_dummy = 0;
        pr_phase = PH_SEL;
        res.push_back(result_of(KIND_BUS_READ, ctl_addr(), 1'b0, 16'h0000, STATUS_OK));
    endfunction

    function automatic void begin_poll(phase_t next, ref rsp_t res [$]);
        pr_polls = '0;
        pr_phase = next;
        res.push_back(result_of(KIND_BUS_READ, io_addr() + 10'd7, 1'b0, 16'h0000, STATUS_OK));
    endfunction

    function automatic void close_sector(ref rsp_t res [$]);
        pr_left = pr_left - 1'b1;
        pr_lba  = pr_lba + 1'b1;
        if (pr_left == 0)
            close_request(STATUS_OK, res);
        else
            open_sector(res);
    endfunction

    // one status read of a wait; returns 1 when the wanted condition is seen
    function automatic bit poll_status(logic [7:0] st, logic [7:0] mask, logic [7:0] want,
                                       ref rsp_t res [$]);
        if ((st & (STAT_ERR | STAT_DF)) != 0)
        begin
            close_request(STATUS_FAULT, res);
            return 1'b0;
        end
        if ((st & mask) == want)
        begin
            pr_polls = '0;
            return 1'b1;
        end
        pr_polls = pr_polls + 1'b1;
        // a limit of zero behaves like one
        if (pr_polls >= poll_max)
            close_request(STATUS_TIMEOUT, res);
        else
            res.push_back(result_of(KIND_BUS_READ, io_addr() + 10'd7, 1'b0, 16'h0000,
                                    STATUS_OK));
        return 1'b0;
    endfunction

    function automatic void advance_sequencer(req_t it, ref rsp_t res [$]);
        logic [7:0]  st;
        logic [29:0] lba_end;
        logic [9:0]  io;
        res.delete();
        st = it.data_in[7:0];
        case (it.mode)
            MODE_START:
                if (pr_phase == PH_IDLE)
                begin
                    lba_end = 30'(it.start_lba) + 30'(it.sector_count);
                    if (drive_size[it.device] == 0 || it.sector_count == 0)
                        close_request(STATUS_REJECTED, res);
                    else if (lba_end > 30'(drive_size[it.device]))
                        close_request(STATUS_BEYOND, res);
                    else
                    begin
                        pr_drive = it.device;
                        pr_write = it.is_write;
                        pr_lba   = it.start_lba;
                        pr_left  = it.sector_count;
                        pr_word  = 0;
                        open_sector(res);
                    end
                end
            MODE_RESP:
                case (pr_phase)
                    PH_SEL:
                    begin
                        pr_dummy++;
                        if (pr_dummy < DUMMY_READS)
                            res.push_back(result_of(KIND_BUS_READ, ctl_addr(), 1'b0, 16'h0000,
                                                    STATUS_OK));
                        else
                        begin
                            io = io_addr();
                            res.push_back(result_of(KIND_BUS_WRITE, io + 10'd1, 1'b0, 16'h0000,
                                                    STATUS_OK));
                            res.push_back(result_of(KIND_BUS_WRITE, io + 10'd2, 1'b0, 16'h0001,
                                                    STATUS_OK));
                            res.push_back(result_of(KIND_BUS_WRITE, io + 10'd3, 1'b0,
                                                    {8'h00, pr_lba[7:0]}, STATUS_OK));
                            res.push_back(result_of(KIND_BUS_WRITE, io + 10'd4, 1'b0,
                                                    {8'h00, pr_lba[15:8]}, STATUS_OK));
                            res.push_back(result_of(KIND_BUS_WRITE, io + 10'd5, 1'b0,
                                                    {8'h00, pr_lba[23:16]}, STATUS_OK));
                            res.push_back(result_of(KIND_BUS_WRITE, io + 10'd7, 1'b0,
                                                    {8'h00, pr_write ? CMD_WRITE : CMD_READ},
                                                    STATUS_OK));
                            begin_poll(PH_BSY, res);
                        end
                    end
                    PH_BSY:
                        if (poll_status(st, STAT_BSY, 8'h00, res))
                        begin
                            pr_phase = PH_DRQ;
                            res.push_back(result_of(KIND_BUS_READ, io_addr() + 10'd7, 1'b0,
                                                    16'h0000, STATUS_OK));
                        end
                    PH_DRQ:
                        if (poll_status(st, STAT_DRQ, STAT_DRQ, res))
                        begin
                            pr_word = 0;
                            if (pr_write)
                                pr_phase = PH_WDATA;
                            else
                            begin
                                pr_phase = PH_RDATA;
                                res.push_back(result_of(KIND_BUS_READ, io_addr(), 1'b1,
                                                        16'h0000, STATUS_OK));
                            end
                        end
                    PH_RDATA:
                    begin
                        res.push_back(result_of(KIND_HOST_WORD, 10'h000, 1'b0, it.data_in,
                                                STATUS_OK));
                        pr_word++;
                        if (pr_word < SECTOR_WORDS)
                            res.push_back(result_of(KIND_BUS_READ, io_addr(), 1'b1, 16'h0000,
                                                    STATUS_OK));
                        else
                        begin
                            pr_dummy = 0;
                            pr_phase = PH_POST;
                            res.push_back(result_of(KIND_BUS_READ, ctl_addr(), 1'b0, 16'h0000,
                                                    STATUS_OK));
                        end
                    end
                    PH_POST:
                    begin
                        pr_dummy++;
                        if (pr_dummy < DUMMY_READS)
                            res.push_back(result_of(KIND_BUS_READ, ctl_addr(), 1'b0, 16'h0000,
                                                    STATUS_OK));
                        else if (pr_write)
                            begin_poll(PH_FIN, res);
                        else
                            close_sector(res);
                    end
                    PH_FIN:
                        if (poll_status(st, STAT_BSY, 8'h00, res))
                            close_sector(res);
                    default:
                        ;
                endcase
            MODE_HWORD:
                if (pr_phase == PH_WDATA)
                begin
                    res.push_back(result_of(KIND_BUS_WRITE, io_addr(), 1'b1, it.data_in,
                                            STATUS_OK));
                    pr_word++;
                    if (pr_word >= SECTOR_WORDS)
                    begin
                        pr_dummy = 0;
                        pr_phase = PH_POST;
                        res.push_back(result_of(KIND_BUS_READ, ctl_addr(), 1'b0, 16'h0000,
                                                STATUS_OK));
                    end
                end
            default:
                ;
        endcase
        if (res.size() > 0)
            res[$].last = 1'b1;
    endfunction

    function automatic script_row_t make_row(row_check_e chk, logic [2:0] status,
                                             logic [1:0] mode, logic wr, logic [1:0] dev,
                                             logic [LBA_W-1:0] lba, logic [COUNT_W-1:0] cnt,
                                             logic [15:0] data);
        script_row_t r;
        r.check             = chk;
        r.status            = status;
        r.item.mode         = mode;
        r.item.is_write     = wr;
        r.item.device       = dev;
        r.item.start_lba    = lba;
        r.item.sector_count = cnt;
        r.item.data_in      = data;
        return r;
    endfunction

    // mostly short, now and then long
    function automatic int idle_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(1, 3);
        if (r < 19)
            return $urandom_range(4, 12);
        return $urandom_range(25, 80);
    endfunction

    // status byte for a wait on (st & mask) == want, with an occasional fault
    function automatic logic [7:0] status_byte(logic [7:0] mask, logic [7:0] want);
        logic [7:0] b;
        b = 8'($urandom) & ~(STAT_ERR | STAT_DF);
        if (fault_odds != 0 && $urandom_range(1, fault_odds) == 1)
        begin
            case ($urandom_range(0, 2))
                0: b = b | STAT_ERR;
                1: b = b | STAT_DF;
                default: b = b | STAT_ERR | STAT_DF;
            endcase
        end
        else if ($urandom_range(0, 3) == 0)
            b = (b & ~mask) | (~want & mask);
        else
            b = (b & ~mask) | want;
        return b;
    endfunction

    task automatic offer(input req_t it, input row_check_e chk, input logic [2:0] status);
        rsp_t outcome [$];
        int gap;
        if (steady_left > 0)
        begin
            steady_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 39) == 0)
        begin
            steady_left = $urandom_range(20, 60);
            gap = 0;
        end
        else if ($urandom_range(0, 1) == 0)
            gap = 0;
        else
            gap = idle_length();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= it;
        do
            @(posedge clk);
        while (req_stall !== 1'b0);
        advance_sequencer(it, outcome);
        case (chk)
            BY_MODEL:
                foreach (outcome[i])
                    results_due.push_back(outcome[i]);
            DONE_WITH:
                results_due.push_back(result_of(KIND_DONE, 10'h000, 1'b0, 16'h0000, status)
                                      | rsp_t'(1));
            default:
                ;
        endcase
    endtask

    task automatic set_register(input logic [CFG_INDEX_W-1:0] idx, input logic [SIZE_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        case (idx)
            CFG_SECTORS_DEV0, CFG_SECTORS_DEV1, CFG_SECTORS_DEV2, CFG_SECTORS_DEV3:
                drive_size[idx[1:0]] = val;
            CFG_POLL_LIMIT:
                poll_max = val[POLL_W-1:0];
            default:
                ;
        endcase
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic apply_settings(input logic [SIZE_W-1:0] s0, input logic [SIZE_W-1:0] s1,
                                  input logic [SIZE_W-1:0] s2, input logic [SIZE_W-1:0] s3,
                                  input logic [SIZE_W-1:0] polls);
        set_register(CFG_SECTORS_DEV0, s0);
        set_register(CFG_SECTORS_DEV1, s1);
        set_register(CFG_SECTORS_DEV2, s2);
        set_register(CFG_SECTORS_DEV3, s3);
        set_register(CFG_POLL_LIMIT, polls);
    endtask

    // drain everything, then give requests without results time to pass
    task automatic quiesce();
        @(negedge clk);
        req_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic compose_item(output req_t it, output bit noise);
        logic [95:0] bits;
        longint unsigned size;
        longint unsigned top;
        logic [COUNT_W-1:0] cnt;
        bits  = {$urandom, $urandom, $urandom};
        it    = bits[$bits(req_t)-1:0];
        noise = ($urandom_range(0, 11) == 0);
        if (noise)
        begin
            // pick a mode that the current phase ignores
            forever
            begin
                it.mode = $urandom_range(0, 3);
                if (it.mode == MODE_UNUSED)
                    break;
                if (it.mode == MODE_START && pr_phase != PH_IDLE)
                    break;
                if (it.mode == MODE_RESP && (pr_phase == PH_IDLE || pr_phase == PH_WDATA))
                    break;
                if (it.mode == MODE_HWORD && pr_phase != PH_WDATA)
                    break;
            end
            return;
        end
        case (pr_phase)
            PH_IDLE:
            begin
                it.mode    = MODE_START;
                fault_odds = ($urandom_range(0, 2) == 0) ? 4 : 0;
                if ($urandom_range(0, 4) != 0)
                begin
                    cnt  = ($urandom_range(0, 7) == 0) ? 16'd2 : 16'd1;
                    size = drive_size[it.device];
                    it.sector_count = cnt;
                    if (size >= cnt)
                    begin
                        top = size - cnt;
                        if (top > 64'h0FFF_FFFF)
                            top = 64'h0FFF_FFFF;
                        case ($urandom_range(0, 3))
                            0: it.start_lba = '0;
                            1: it.start_lba = top[LBA_W-1:0];
                            default: it.start_lba = LBA_W'(longint'($urandom) % (top + 1));
                        endcase
                    end
                end
            end
            PH_WDATA:
                it.mode = MODE_HWORD;
            PH_BSY, PH_FIN:
            begin
                it.mode         = MODE_RESP;
                it.data_in[7:0] = status_byte(STAT_BSY, 8'h00);
            end
            PH_DRQ:
            begin
                it.mode         = MODE_RESP;
                it.data_in[7:0] = status_byte(STAT_DRQ, STAT_DRQ);
            end
            default:
                it.mode = MODE_RESP;
        endcase
    endtask

    task automatic random_phase(input int budget);
        int counted;
        req_t it;
        bit noise;
        counted = 0;
        while (counted < budget || pr_phase != PH_IDLE)
        begin
            compose_item(it, noise);
            offer(it, BY_MODEL, STATUS_OK);
            if (!noise)
                counted++;
        end
    endtask

    task automatic note_mismatch(input string what, input rsp_t want, input rsp_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%s at %0t: expected kind %0d port %h wide %0d data %h status %0d last %0d,",
                     what, $realtime, want.kind, want.port, want.wide, want.data_out,
                     want.status, want.last,
                     " got kind %0d port %h wide %0d data %h status %0d last %0d",
                     got.kind, got.port, got.wide, got.data_out, got.status, got.last);
    endtask

    always @(posedge clk)
    begin : check_results
        rsp_t want;
        rsp_t got;
        if (rst_n === 1'b1 && rsp_valid === 1'b1 && rsp_stall === 1'b0)
        begin
            got = rsp;
            if (results_due.size() == 0)
                note_mismatch("unexpected result", '0, got);
            else
            begin
                want = results_due.pop_front();
                if (got.kind !== want.kind || got.port !== want.port ||
                    got.wide !== want.wide || got.data_out !== want.data_out ||
                    got.status !== want.status || got.last !== want.last)
                    note_mismatch("result mismatch", want, got);
            end
        end
    end

    // result side: random stall stretches, plus one long hold-off during sector data
    initial
    begin : result_stalls
        int hold_left;
        bit holding;
        bit pressure_done;
        hold_left     = 0;
        holding       = 1'b0;
        pressure_done = 1'b0;
        rsp_stall     = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!pressure_done && (pr_phase == PH_RDATA || pr_phase == PH_WDATA) &&
                pr_word >= 16)
            begin
                pressure_done = 1'b1;
                holding       = 1'b1;
                hold_left     = 400;
            end
            else if (hold_left == 0)
            begin
                holding = !holding;
                if (holding)
                    hold_left = idle_length();
                else if ($urandom_range(0, 3) == 0)
                    hold_left = $urandom_range(30, 120);
                else
                    hold_left = $urandom_range(1, 8);
            end
            hold_left--;
            rsp_stall <= holding;
        end
    end

    initial
    begin
        #12_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        foreach (drive_size[i])
            drive_size[i] = '0;
        poll_max = POLL_LIMIT_RESET;
        pr_phase = PH_IDLE;
        pr_lba   = '0;
        pr_left  = '0;
        pr_word  = 0;
        pr_dummy = 0;
        pr_polls = '0;
        pr_drive = '0;
        pr_write = 1'b0;

        // reset defaults: no drive anywhere, ignored modes
        script.push_back(make_row(DONE_WITH, STATUS_REJECTED, MODE_START, 1'b0, 2'd0,
                                  28'h0, 16'd1, 16'h0000));
        script.push_back(make_row(NO_RESULT, STATUS_OK, MODE_HWORD, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'hFFFF));
        script.push_back(make_row(NO_RESULT, STATUS_OK, MODE_UNUSED, 1'b1, 2'd3,
                                  28'hFFF_FFFF, 16'hFFFF, 16'hFFFF));
        script.push_back(make_row(NO_RESULT, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h0080));
        script.push_back(make_row(SETUP_DRIVES, STATUS_OK, MODE_START, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h0000));
        // size checks, including a sum that needs the wide adder
        script.push_back(make_row(DONE_WITH, STATUS_REJECTED, MODE_START, 1'b0, 2'd1,
                                  28'h0, 16'd0, 16'h0000));
        script.push_back(make_row(DONE_WITH, STATUS_BEYOND, MODE_START, 1'b0, 2'd1,
                                  28'd15, 16'd2, 16'h0000));
        script.push_back(make_row(DONE_WITH, STATUS_BEYOND, MODE_START, 1'b0, 2'd0,
                                  28'hFFF_FFFF, 16'hFFFF, 16'h0000));
        // write on an oversized drive, then busy start and stray host word
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_START, 1'b1, 2'd3,
                                  28'hFFF_FFFF, 16'hFFFF, 16'h1234));
        script.push_back(make_row(NO_RESULT, STATUS_OK, MODE_START, 1'b0, 2'd0,
                                  28'h0, 16'd1, 16'h0000));
        script.push_back(make_row(NO_RESULT, STATUS_OK, MODE_HWORD, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h5A5A));
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'hFFFF));
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h0000));
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h8001));
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h00FF));
        // busy twice with a poll limit of two times out
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'hC380));
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h0080));
        // read on the secondary master, faulted in the drq wait
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_START, 1'b0, 2'd2,
                                  28'h0, 16'd1, 16'h0000));
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h1111));
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h2222));
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h4444));
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h8888));
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h0050));
        script.push_back(make_row(BY_MODEL, STATUS_OK, MODE_RESP, 1'b0, 2'd0,
                                  28'h0, 16'd0, 16'h0021));

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (script[i])
        begin
            if (script[i].check == SETUP_DRIVES)
            begin
                quiesce();
                apply_settings(29'h1000_0000, 29'd16, 29'd1, 29'h1FFF_FFFF, 29'd2);
            end
            else
                offer(script[i].item, script[i].check, script[i].status);
        end

        quiesce();
        apply_settings(29'd64, 29'h1000_0000, 29'd0, 29'h1FFF_FFFF, 29'd3);
        set_register(CFG_UNUSED_INDEX, 29'h1FFF_FFFF);
        random_phase(100);

        quiesce();
        apply_settings($urandom_range(1, 600), $urandom_range(1, 40), $urandom,
                       $urandom_range(0, 3), 29'd0);
        random_phase(100);

        // upper bits beyond the poll register are dropped
        quiesce();
        apply_settings(29'd1, 29'd2, 29'h1000_0000, $urandom, 29'h1FFF_FFFF);
        random_phase(100);

        quiesce();
        apply_settings(29'h1FFF_FFFF, 29'd300, 29'd8, 29'd0, 29'd1);
        random_phase(60);

        quiesce();
        repeat (20) @(posedge clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

### ata_pio_sector_sequencer.f
design/ata_seq_pkg.sv
design/ata_seq_engine.sv
design/ata_seq_outq.sv
design/ata_pio_sector_sequencer.sv
tb/tb_top.sv
